@@ sv/chrl_pkg.sv @@
package chrl_pkg;

	localparam int unsigned MAX_BACKENDS = 16;

	localparam logic [63:0] FNV_BASIS = 64'd14695981039346656037;
	// prime = 2^40 + 0x1B3
	localparam int unsigned FNV_PRIME_SHIFT = 40;
	localparam logic [8:0]  FNV_PRIME_LOW   = 9'h1B3;

	typedef enum logic [1:0] {
		ACT_CLEAR  = 2'd0,
		ACT_INSERT = 2'd1,
		ACT_LOOKUP = 2'd2,
		ACT_NONE   = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		STAT_OK      = 2'd0,
		STAT_NO_BE   = 2'd1,
		STAT_DUP     = 2'd2,
		STAT_FULL    = 2'd3
	} status_t;

	typedef enum logic {
		CFG_BACKEND_COUNT = 1'b0,
		CFG_HEALTHY_MASK  = 1'b1
	} cfg_reg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SRD,
		ST_SCMP,
		ST_DEC,
		ST_SHRD,
		ST_SHWR,
		ST_INS,
		ST_WRD,
		ST_WCHK,
		ST_EMIT
	} state_t;

	function automatic logic [63:0] fnv_step(input logic [63:0] acc, input logic [7:0] b);
		logic [63:0] x;
		x = acc ^ {56'd0, b};
		return (x << FNV_PRIME_SHIFT) + (x * {55'd0, FNV_PRIME_LOW});
	endfunction

endpackage

@@ sv/consistent_hash_ring_lookup.sv @@
// Consistent-hash ring lookup.
// Input channel (in_valid/in_stall): one key byte per transfer with action,
// last_byte and backend_id. Non-final bytes and clears do not stall the
// input. A final insert or lookup byte starts the sequencer: a linear
// search over the sorted ring, then either a shift of the points above
// the insert position followed by the write, or a forward walk for a
// healthy backend. in_stall is high throughout. All of it runs through
// the one ring memory read port.
// Output channel (out_valid/out_stall): one result per final byte, held in
// an output register; while it waits under out_stall, further non-final
// bytes are still taken, and a new result waits until the register frees.
// Config channel (cfg_valid/cfg_ready): cfg_ready is always high; index 0
// writes backend_count, index 1 writes healthy_mask. Write only when idle.
// Reset clears the point count and backend count, loads the FNV basis
// into the hash, and sets the mask to all ones. The ring memory itself is
// not cleared; only the first point_count entries are ever read.
module consistent_hash_ring_lookup #(
	parameter int unsigned RING_ENTRIES = 256
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [1:0]              action,
	input  logic [7:0]              key_byte,
	input  logic                    last_byte,
	input  logic [3:0]              backend_id,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [1:0]              status,
	output logic [3:0]              chosen_backend,
	output logic [63:0]             key_hash,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic                    cfg_index,
	input  logic [15:0]             cfg_data
);
	import chrl_pkg::*;

	localparam int unsigned AW = (RING_ENTRIES > 1) ? $clog2(RING_ENTRIES) : 1;
	localparam int unsigned CW = $clog2(RING_ENTRIES + 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(RING_ENTRIES);

	// ring memory: {hash, backend}
	logic [67:0] mem_q [RING_ENTRIES];
	logic [67:0] rdata_q;
	logic [AW-1:0] rd_addr, wr_addr;
	logic [67:0] wr_data;
	logic wr_en;

	state_t state_q, state_d;
	logic [63:0] acc_q, acc_d;
	logic [63:0] h_q, h_d;
	logic [3:0]  bid_q, bid_d;
	logic        ins_q, ins_d;
	logic        eq_q, eq_d;
	logic [CW-1:0] count_q, count_d;
	logic [CW-1:0] idx_q, idx_d;   // search position, then shift pointer
	logic [CW-1:0] pos_q, pos_d;
	logic [AW-1:0] wi_q, wi_d;     // walk index
	logic [CW-1:0] wk_q, wk_d;     // points tried
	logic [1:0]  rstat_q, rstat_d;
	logic [3:0]  rchosen_q, rchosen_d;

	logic [4:0]  bcount_q;
	logic [15:0] hmask_q;

	logic        out_valid_q, out_valid_d;
	logic [1:0]  status_q;
	logic [3:0]  chosen_q;
	logic [63:0] hash_q;
	logic        out_load;

	logic        in_xfer;
	logic [63:0] next_hash;
	logic [63:0] rd_hash;
	logic [3:0]  rd_bid;
	logic        usable;
	logic [CW-1:0] idx_dec;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_xfer   = in_valid && !in_stall;
	assign cfg_ready = 1'b1;
	assign next_hash = fnv_step(acc_q, key_byte);
	assign rd_hash   = rdata_q[67:4];
	assign rd_bid    = rdata_q[3:0];
	assign idx_dec   = idx_q - CW'(1);
	// counts above MAX_BACKENDS act as MAX_BACKENDS; health bit is index mod 16
	assign usable = ({1'b0, rd_bid} < bcount_q) && (32'(rd_bid) < MAX_BACKENDS)
		&& hmask_q[rd_bid];

	assign out_valid      = out_valid_q;
	assign status         = status_q;
	assign chosen_backend = chosen_q;
	assign key_hash       = hash_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rdata_q <= mem_q[rd_addr];
	end

	always_comb begin
		state_d   = state_q;
		acc_d     = acc_q;
		h_d       = h_q;
		bid_d     = bid_q;
		ins_d     = ins_q;
		eq_d      = eq_q;
		count_d   = count_q;
		idx_d     = idx_q;
		pos_d     = pos_q;
		wi_d      = wi_q;
		wk_d      = wk_q;
		rstat_d   = rstat_q;
		rchosen_d = rchosen_q;
		rd_addr   = idx_q[AW-1:0];
		wr_addr   = idx_q[AW-1:0];
		wr_data   = rdata_q;
		wr_en     = 1'b0;
		out_load  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_xfer) begin
					unique case (action)
						ACT_CLEAR: begin
							count_d = '0;
							acc_d   = FNV_BASIS;
						end
						ACT_INSERT, ACT_LOOKUP: begin
							if (last_byte) begin
								acc_d   = FNV_BASIS;
								h_d     = next_hash;
								bid_d   = backend_id;
								ins_d   = (action == ACT_INSERT);
								idx_d   = '0;
								eq_d    = 1'b0;
								state_d = ST_SRD;
							end else begin
								acc_d = next_hash;
							end
						end
						default: ;
					endcase
				end
			end
			ST_SRD: begin
				if (idx_q == count_q) begin
					pos_d   = count_q;
					eq_d    = 1'b0;
					state_d = ST_DEC;
				end else begin
					state_d = ST_SCMP;
				end
			end
			ST_SCMP: begin
				if (rd_hash < h_q) begin
					idx_d   = idx_q + CW'(1);
					state_d = ST_SRD;
				end else begin
					pos_d   = idx_q;
					eq_d    = (rd_hash == h_q);
					state_d = ST_DEC;
				end
			end
			ST_DEC: begin
				rchosen_d = '0;
				if (ins_q) begin
					if (eq_q) begin
						rstat_d = STAT_DUP;
						state_d = ST_EMIT;
					end else if (count_q == FULL_CNT) begin
						rstat_d = STAT_FULL;
						state_d = ST_EMIT;
					end else begin
						idx_d   = count_q;
						state_d = (count_q > pos_q) ? ST_SHRD : ST_INS;
					end
				end else begin
					if (count_q == '0 || bcount_q == '0) begin
						rstat_d = STAT_NO_BE;
						state_d = ST_EMIT;
					end else begin
						wi_d    = (pos_q >= count_q) ? '0 : pos_q[AW-1:0];
						wk_d    = '0;
						state_d = ST_WRD;
					end
				end
			end
			ST_SHRD: begin
				rd_addr = idx_dec[AW-1:0];
				state_d = ST_SHWR;
			end
			ST_SHWR: begin
				wr_en   = 1'b1;
				wr_addr = idx_q[AW-1:0];
				wr_data = rdata_q;
				idx_d   = idx_dec;
				state_d = (idx_dec > pos_q) ? ST_SHRD : ST_INS;
			end
			ST_INS: begin
				wr_en   = 1'b1;
				wr_addr = pos_q[AW-1:0];
				wr_data = {h_q, bid_q};
				count_d = count_q + CW'(1);
				rstat_d = STAT_OK;
				state_d = ST_EMIT;
			end
			ST_WRD: begin
				rd_addr = wi_q;
				state_d = ST_WCHK;
			end
			ST_WCHK: begin
				if (usable) begin
					rstat_d   = STAT_OK;
					rchosen_d = rd_bid;
					state_d   = ST_EMIT;
				end else if (wk_q + CW'(1) == count_q) begin
					rstat_d = STAT_NO_BE;
					state_d = ST_EMIT;
				end else begin
					wk_d    = wk_q + CW'(1);
					wi_d    = ((CW'(wi_q) + CW'(1)) == count_q) ? '0 : wi_q + AW'(1);
					state_d = ST_WRD;
				end
			end
			ST_EMIT: begin
				if (!out_valid_q || !out_stall) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		out_valid_d = out_valid_q;
		if (out_valid_q && !out_stall) begin
			out_valid_d = 1'b0;
		end
		if (out_load) begin
			out_valid_d = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			acc_q       <= FNV_BASIS;
			count_q     <= '0;
			out_valid_q <= 1'b0;
			bcount_q    <= '0;
			hmask_q     <= '1;
		end else begin
			state_q     <= state_d;
			acc_q       <= acc_d;
			count_q     <= count_d;
			out_valid_q <= out_valid_d;
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					CFG_BACKEND_COUNT: bcount_q <= cfg_data[4:0];
					CFG_HEALTHY_MASK:  hmask_q  <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		h_q       <= h_d;
		bid_q     <= bid_d;
		ins_q     <= ins_d;
		eq_q      <= eq_d;
		idx_q     <= idx_d;
		pos_q     <= pos_d;
		wi_q      <= wi_d;
		wk_q      <= wk_d;
		rstat_q   <= rstat_d;
		rchosen_q <= rchosen_d;
		if (out_load) begin
			status_q <= rstat_q;
			chosen_q <= rchosen_q;
			hash_q   <= h_q;
		end
	end

endmodule

@@ sv/chrl_checker.sv @@
module chrl_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic [1:0]  action,
	input logic        last_byte,
	input logic        out_valid,
	input logic        out_stall,
	input logic [1:0]  status,
	input logic [3:0]  chosen_backend,
	input logic [63:0] key_hash
);
	import chrl_pkg::*;

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(key_hash) && $stable(status))
		else $error("stalled result changed");

	// chosen backend only on success
	a_chosen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != STAT_OK |-> chosen_backend == 4'd0)
		else $error("chosen backend on failed result");

	// clears, no-op bytes and non-final bytes never start the sequencer
	a_short_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && (action == ACT_CLEAR || action == ACT_NONE || !last_byte)
		|=> !in_stall)
		else $error("short item stalled input");

	// a final insert or lookup byte always starts the sequencer
	a_final_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && last_byte && (action == ACT_INSERT || action == ACT_LOOKUP)
		|=> in_stall)
		else $error("final byte did not start work");

endmodule

bind consistent_hash_ring_lookup chrl_checker u_chrl_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(in_valid),
	.in_stall(in_stall),
	.action(action),
	.last_byte(last_byte),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.status(status),
	.chosen_backend(chosen_backend),
	.key_hash(key_hash)
);
